[hw/rtl/macs_pkg.sv]
// Package for the moving average crossover signal block.
// Holds the payload types, register indexes, reset values and signal codes.
// Depends on nothing.
`default_nettype none

package macs_pkg;

   localparam int SHORT_WINDOW_BITS = 6;
   localparam int LONG_WINDOW_BITS  = 7;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = LONG_WINDOW_BITS;

   typedef logic signed [1:0]            signal_type;
   typedef logic [CSR_INDEX_BITS-1:0]    csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]     csr_data_type;
   typedef logic [SHORT_WINDOW_BITS-1:0] short_window_type;
   typedef logic [LONG_WINDOW_BITS-1:0]  long_window_type;

   localparam csr_index_type CSR_SHORT_WINDOW = 2'd0;
   localparam csr_index_type CSR_LONG_WINDOW  = 2'd1;

   localparam short_window_type SHORT_WINDOW_RESET = 6'd5;
   localparam long_window_type  LONG_WINDOW_RESET  = 7'd20;

   localparam signal_type SIG_HOLD = 2'sb00;
   localparam signal_type SIG_BUY  = 2'sb01;
   localparam signal_type SIG_SELL = 2'sb11;

endpackage

`default_nettype wire

[hw/rtl/moving_average_crossover_signal_top.sv]
// Top level of the moving average crossover signal block.
// Holds the price delay line, the running sums and the crossover compare.
// Depends on macs_pkg.
`default_nettype none

// The block takes one price beat per cycle while the result side is not stalled and returns one
// result beat for each. The short and long running sums are updated from the new price and the
// two prices leaving the windows in the cycle the price is accepted; the delay line memory is
// read ahead, into registers, at the slots the next price will need. The new sums are held in
// the p_ stage registers; when that stage advances, each sum is multiplied by the other window
// and the products are compared into the output register, from which the result beat is offered.
// Writing either window register, or a price with series_start set, starts a new series; the
// delay line is cleared at once through per-entry valid bits, so no clearing pass follows reset
// or a register write.
module moving_average_crossover_signal_top #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [PRICE_BITS-1:0]     req_price,
   input  wire logic                      req_series_start,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output macs_pkg::signal_type           rsp_signal,
   output logic                           rsp_order_valid,
   output logic [PRICE_BITS-1:0]          rsp_order_price,
   output logic                           rsp_config_error,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire macs_pkg::csr_index_type   csr_index,
   input  wire macs_pkg::csr_data_type    csr_data
);

   import macs_pkg::*;

   localparam int PTR_BITS  = $clog2(MAX_WINDOW);
   localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS  = (CNT_BITS > LONG_WINDOW_BITS) ? CNT_BITS : LONG_WINDOW_BITS;
   localparam int SLOT_BITS = PTR_BITS + 8;
   localparam int SUM_BITS  = PRICE_BITS + PTR_BITS;
   localparam int PROD_BITS = SUM_BITS + LONG_WINDOW_BITS;
   localparam logic [SLOT_BITS-1:0] MAX_SLOT  = SLOT_BITS'(MAX_WINDOW);
   localparam logic [PTR_BITS-1:0]  LAST_PTR  = PTR_BITS'(MAX_WINDOW - 1);
   localparam logic [CNT_BITS-1:0]  MAX_COUNT = CNT_BITS'(MAX_WINDOW);
   localparam logic [CMP_BITS-1:0]  MAX_CMP   = CMP_BITS'(MAX_WINDOW);

   logic [PRICE_BITS-1:0] history_mem [MAX_WINDOW];

   short_window_type      short_window_ff, short_window_in;
   long_window_type       long_window_ff, long_window_in;
   logic [MAX_WINDOW-1:0] hist_valid_ff, hist_valid_in;
   logic [PTR_BITS-1:0]   ptr_ff, ptr_in;
   logic [SUM_BITS-1:0]   short_sum_ff, short_sum_in;
   logic [SUM_BITS-1:0]   long_sum_ff, long_sum_in;
   logic [CNT_BITS-1:0]   samples_ff, samples_in;

   logic [PTR_BITS-1:0]   s_addr_ff, s_addr_in;
   logic [PTR_BITS-1:0]   l_addr_ff, l_addr_in;
   logic [PRICE_BITS-1:0] s_rd_ff;
   logic [PRICE_BITS-1:0] l_rd_ff;
   logic                  wr_en_ff;
   logic [PTR_BITS-1:0]   wr_addr_ff;
   logic [PRICE_BITS-1:0] wr_data_ff;

   logic                  p_valid_ff, p_valid_in;
   logic [PRICE_BITS-1:0] p_price_ff;
   logic [SUM_BITS-1:0]   p_short_sum_ff;
   logic [SUM_BITS-1:0]   p_long_sum_ff;
   logic                  p_enough_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   signal_type            rsp_signal_ff, rsp_signal_in;
   logic                  rsp_order_valid_ff;
   logic [PRICE_BITS-1:0] rsp_order_price_ff;
   logic                  rsp_config_error_ff;

   logic                  accept;
   logic                  csr_write;
   logic                  p_adv;
   logic [PTR_BITS-1:0]   ptr_cur;
   logic [PTR_BITS-1:0]   ptr_next;
   logic [PRICE_BITS-1:0] old_s;
   logic [PRICE_BITS-1:0] old_l;
   logic [SUM_BITS-1:0]   short_sum_next;
   logic [SUM_BITS-1:0]   long_sum_next;
   logic [CNT_BITS-1:0]   samples_base;
   logic [CNT_BITS-1:0]   samples_next;
   logic                  enough_next;
   logic                  cfg_error;
   logic [PROD_BITS-1:0]  prod_s;
   logic [PROD_BITS-1:0]  prod_l;

   function automatic logic [PTR_BITS-1:0] leaving_slot(input logic [PTR_BITS-1:0] ptr,
                                                       input logic [CMP_BITS-1:0] win);
      logic [SLOT_BITS-1:0] wc;
      logic [SLOT_BITS-1:0] pe;
      logic [SLOT_BITS-1:0] slot;
      pe = SLOT_BITS'(ptr);
      wc = (SLOT_BITS'(win) > MAX_SLOT) ? MAX_SLOT : SLOT_BITS'(win);
      if (pe >= wc) begin
         slot = pe - wc;
      end else begin
         slot = pe + MAX_SLOT - wc;
      end
      if (slot == MAX_SLOT) begin
         slot = '0;
      end
      return slot[PTR_BITS-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign p_adv     = p_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !p_valid_ff || p_adv;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ptr_cur = req_series_start ? '0 : ptr_ff;
      ptr_next = (ptr_cur == LAST_PTR) ? '0 : ptr_cur + 1'b1;

      if (req_series_start || !hist_valid_ff[s_addr_ff]) begin
         old_s = '0;
      end else if (wr_en_ff && (wr_addr_ff == s_addr_ff)) begin
         old_s = wr_data_ff;
      end else begin
         old_s = s_rd_ff;
      end
      if (req_series_start || !hist_valid_ff[l_addr_ff]) begin
         old_l = '0;
      end else if (wr_en_ff && (wr_addr_ff == l_addr_ff)) begin
         old_l = wr_data_ff;
      end else begin
         old_l = l_rd_ff;
      end

      short_sum_next = (req_series_start ? '0 : short_sum_ff) + SUM_BITS'(req_price)
                       - SUM_BITS'(old_s);
      long_sum_next  = (req_series_start ? '0 : long_sum_ff) + SUM_BITS'(req_price)
                       - SUM_BITS'(old_l);

      samples_base = req_series_start ? '0 : samples_ff;
      samples_next = (samples_base < MAX_COUNT) ? samples_base + 1'b1 : samples_base;
      enough_next  = CMP_BITS'(samples_next) >= CMP_BITS'(long_window_ff);
   end

   always_comb begin
      short_window_in = short_window_ff;
      long_window_in  = long_window_ff;
      hist_valid_in   = hist_valid_ff;
      ptr_in          = ptr_ff;
      short_sum_in    = short_sum_ff;
      long_sum_in     = long_sum_ff;
      samples_in      = samples_ff;
      priority if (csr_write) begin
         if (csr_index == CSR_SHORT_WINDOW) begin
            short_window_in = csr_data[SHORT_WINDOW_BITS-1:0];
         end
         if (csr_index == CSR_LONG_WINDOW) begin
            long_window_in = csr_data;
         end
         if ((csr_index == CSR_SHORT_WINDOW) || (csr_index == CSR_LONG_WINDOW)) begin
            hist_valid_in = '0;
            ptr_in        = '0;
            short_sum_in  = '0;
            long_sum_in   = '0;
            samples_in    = '0;
         end
      end else if (accept) begin
         if (req_series_start) begin
            hist_valid_in = '0;
         end
         hist_valid_in[ptr_cur] = 1'b1;
         ptr_in       = ptr_next;
         short_sum_in = short_sum_next;
         long_sum_in  = long_sum_next;
         samples_in   = samples_next;
      end else begin
         ptr_in = ptr_ff;
      end
      s_addr_in = leaving_slot(ptr_in, CMP_BITS'(short_window_in));
      l_addr_in = leaving_slot(ptr_in, CMP_BITS'(long_window_in));
   end

   always_ff @(posedge clock) begin
      if (accept && !csr_write) begin
         history_mem[ptr_cur] <= req_price;
      end
      s_rd_ff    <= history_mem[s_addr_in];
      l_rd_ff    <= history_mem[l_addr_in];
      wr_addr_ff <= ptr_cur;
      wr_data_ff <= req_price;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_window_ff <= SHORT_WINDOW_RESET;
         long_window_ff  <= LONG_WINDOW_RESET;
         hist_valid_ff   <= '0;
         ptr_ff          <= '0;
         short_sum_ff    <= '0;
         long_sum_ff     <= '0;
         samples_ff      <= '0;
         s_addr_ff       <= leaving_slot('0, CMP_BITS'(SHORT_WINDOW_RESET));
         l_addr_ff       <= leaving_slot('0, CMP_BITS'(LONG_WINDOW_RESET));
         wr_en_ff        <= 1'b0;
         p_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         short_window_ff <= short_window_in;
         long_window_ff  <= long_window_in;
         hist_valid_ff   <= hist_valid_in;
         ptr_ff          <= ptr_in;
         short_sum_ff    <= short_sum_in;
         long_sum_ff     <= long_sum_in;
         samples_ff      <= samples_in;
         s_addr_ff       <= s_addr_in;
         l_addr_ff       <= l_addr_in;
         wr_en_ff        <= accept && !csr_write;
         p_valid_ff      <= p_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_comb begin
      p_valid_in = accept ? 1'b1 : (p_adv ? 1'b0 : p_valid_ff);
      rsp_valid_in = p_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      cfg_error = (short_window_ff == '0) ||
                  (LONG_WINDOW_BITS'(short_window_ff) >= long_window_ff) ||
                  (CMP_BITS'(long_window_ff) > MAX_CMP);
      prod_s = PROD_BITS'(p_short_sum_ff) * PROD_BITS'(long_window_ff);
      prod_l = PROD_BITS'(p_long_sum_ff) * PROD_BITS'(short_window_ff);

      priority if (cfg_error || !p_enough_ff) begin
         rsp_signal_in = SIG_HOLD;
      end else if (prod_s > prod_l) begin
         rsp_signal_in = SIG_BUY;
      end else if (prod_s < prod_l) begin
         rsp_signal_in = SIG_SELL;
      end else begin
         rsp_signal_in = SIG_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_price_ff     <= req_price;
         p_short_sum_ff <= short_sum_next;
         p_long_sum_ff  <= long_sum_next;
         p_enough_ff    <= enough_next;
      end
      if (p_adv) begin
         rsp_signal_ff       <= rsp_signal_in;
         rsp_order_valid_ff  <= rsp_signal_in != SIG_HOLD;
         rsp_order_price_ff  <= p_price_ff;
         rsp_config_error_ff <= cfg_error;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_signal       = rsp_signal_ff;
   assign rsp_order_valid  = rsp_order_valid_ff;
   assign rsp_order_price  = rsp_order_price_ff;
   assign rsp_config_error = rsp_config_error_ff;

   a_order_matches_signal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_order_valid_ff == (rsp_signal_ff != SIG_HOLD)))
      else $error("order flag disagrees with the signal");

   a_error_gives_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_config_error_ff) |-> (rsp_signal_ff == SIG_HOLD))
      else $error("bad window setting produced an order");

   a_series_start_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_series_start && !csr_valid) |=> $onehot(hist_valid_ff))
      else $error("delay line not cleared at the start of a series");

   a_samples_saturate: assert property (@(posedge clock) disable iff (reset)
      samples_ff <= MAX_COUNT)
      else $error("sample count passed the delay line depth");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for moving_average_crossover_signal_top: random price beats under
// random stalls, checked beat by beat against a crossover predictor held in a scoreboard class.
// Depends on macs_pkg and moving_average_crossover_signal_top.
`timescale 1ns / 1ps

class crossover_scoreboard;
   localparam int HISTORY_DEPTH = 64;

   typedef struct {
      macs_pkg::signal_type trade_signal;
      logic                 order_valid;
      logic [31:0]          order_price;
      logic                 config_error;
   } result_beat_type;

   result_beat_type              expected_q[$];
   macs_pkg::short_window_type   short_window;
   macs_pkg::long_window_type    long_window;
   logic [31:0]                  history[HISTORY_DEPTH];
   int unsigned                  write_slot;
   int unsigned                  samples_seen;
   logic [63:0]                  short_sum;
   logic [63:0]                  long_sum;
   int                           failures;

   function new();
      short_window = macs_pkg::SHORT_WINDOW_RESET;
      long_window  = macs_pkg::LONG_WINDOW_RESET;
      failures     = 0;
      restart_series();
   endfunction

   function void restart_series();
      foreach (history[i]) history[i] = '0;
      write_slot   = 0;
      samples_seen = 0;
      short_sum    = '0;
      long_sum     = '0;
   endfunction

   function int unsigned leaving_slot(int unsigned width);
      int unsigned clamped;
      clamped = (width > HISTORY_DEPTH) ? HISTORY_DEPTH : width;
      return (write_slot + HISTORY_DEPTH - clamped) % HISTORY_DEPTH;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void write_register(macs_pkg::csr_index_type index, macs_pkg::csr_data_type data);
      if (index == macs_pkg::CSR_SHORT_WINDOW) begin
         short_window = data[macs_pkg::SHORT_WINDOW_BITS-1:0];
         restart_series();
      end else if (index == macs_pkg::CSR_LONG_WINDOW) begin
         long_window = data;
         restart_series();
      end
   endfunction

   function void note_price(logic [31:0] price, logic series_start);
      result_beat_type beat;
      logic [63:0]     short_side;
      logic [63:0]     long_side;
      logic            bad_windows;
      logic [31:0]     short_leaving;
      logic [31:0]     long_leaving;
      if (series_start) restart_series();
      bad_windows = (short_window == 0) || (short_window >= long_window) ||
                    (long_window > HISTORY_DEPTH);
      short_leaving = history[leaving_slot(short_window)];
      long_leaving  = history[leaving_slot(long_window)];
      short_sum = short_sum + price - short_leaving;
      long_sum  = long_sum + price - long_leaving;
      history[write_slot] = price;
      write_slot = (write_slot + 1) % HISTORY_DEPTH;
      if (samples_seen < HISTORY_DEPTH) samples_seen++;
      beat.trade_signal = macs_pkg::SIG_HOLD;
      if (!bad_windows && samples_seen >= long_window) begin
         short_side = short_sum * long_window;
         long_side  = long_sum * short_window;
         if (short_side > long_side) begin
            beat.trade_signal = macs_pkg::SIG_BUY;
         end else if (short_side < long_side) begin
            beat.trade_signal = macs_pkg::SIG_SELL;
         end
      end
      beat.order_valid  = (beat.trade_signal != macs_pkg::SIG_HOLD);
      beat.order_price  = price;
      beat.config_error = bad_windows;
      expected_q.push_back(beat);
   endfunction

   function void check_result(macs_pkg::signal_type trade_signal, logic order_valid,
                              logic [31:0] order_price, logic config_error);
      result_beat_type want;
      if (expected_q.size() == 0) begin
         $error("result beat with no price outstanding: signal %0d, order_price %h",
                trade_signal, order_price);
         failures++;
         return;
      end
      want = expected_q.pop_front();
      if (trade_signal !== want.trade_signal) begin
         $error("signal: expected %0d, got %0d", want.trade_signal, trade_signal);
         failures++;
      end
      if (order_valid !== want.order_valid) begin
         $error("order_valid: expected %b, got %b", want.order_valid, order_valid);
         failures++;
      end
      if (order_price !== want.order_price) begin
         $error("order_price: expected %h, got %h", want.order_price, order_price);
         failures++;
      end
      if (config_error !== want.config_error) begin
         $error("config_error: expected %b, got %b", want.config_error, config_error);
         failures++;
      end
   endfunction
endclass

module tb;
   import macs_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_ITEMS    = 1750;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_PERCENT    = 35;
   localparam csr_index_type CSR_SPARE_LOW  = 2'd2;
   localparam csr_index_type CSR_SPARE_HIGH = 2'd3;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [31:0]   req_price = '0;
   logic          req_series_start = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   signal_type    rsp_signal;
   logic          rsp_order_valid;
   logic [31:0]   rsp_order_price;
   logic          rsp_config_error;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_SHORT_WINDOW;
   csr_data_type  csr_data = '0;

   logic          steady_run = 1'b0;
   int            holds_asked = 0;
   int            holds_done = 0;
   int            hold_left = 0;
   int            cycle_count = 0;
   logic [31:0]   walk_price = 32'h0010_0000;

   crossover_scoreboard book = new();

   moving_average_crossover_signal_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HOLD_OFF_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         book.check_result(rsp_signal, rsp_order_valid, rsp_order_price, rsp_config_error);
      end
   end

   task automatic send_price(input logic [31:0] price, input logic series_start);
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_price        <= price;
      req_series_start <= series_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_price(price, series_start);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.write_register(index, data);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_windows(input int unsigned short_w, input int unsigned long_w);
      drain();
      write_csr(CSR_SHORT_WINDOW, csr_data_type'(short_w));
      write_csr(CSR_LONG_WINDOW, csr_data_type'(long_w));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] next_price(input int unsigned mode);
      case (mode)
         0: walk_price = $urandom();
         1: begin
            if ($urandom_range(1) == 1) walk_price = walk_price + $urandom_range(0, 4095);
            else walk_price = walk_price - $urandom_range(0, 4095);
         end
         2: if ($urandom_range(7) == 0) walk_price = $urandom();
         default: walk_price = 32'hFFFF_FFFF - $urandom_range(0, 65535);
      endcase
      return walk_price;
   endfunction

   task automatic run_phase(input int unsigned items, input int unsigned mode,
                            input int unsigned start_percent);
      int unsigned spare_at;
      logic        opens;
      spare_at = ($urandom_range(3) == 0) ? $urandom_range(1, items - 1) : items;
      for (int unsigned k = 0; k < items; k++) begin
         if (k == spare_at) begin
            drain();
            write_csr(($urandom_range(1) == 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH,
                      csr_data_type'($urandom()));
            csr_valid <= 1'b0;
         end
         opens = ($urandom_range(99) < start_percent) || (k == 0 && $urandom_range(1) == 1);
         send_price(next_price(mode), opens);
      end
   endtask

   initial begin
      int unsigned sent;
      int unsigned phase;
      int unsigned items;
      int unsigned short_w;
      int unsigned long_w;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Windows straight out of reset, then the tightest legal pair.
      send_price(32'hFFFF_FFFF, 1'b1);
      send_price(32'h0000_0000, 1'b0);
      send_price(32'h0001_0000, 1'b0);
      set_windows(1, 2);
      send_price(32'h0000_0000, 1'b1);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h0000_0000, 1'b0);
      send_price(32'h0000_0000, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      // Writes to unused register slots must leave the running series alone.
      drain();
      write_csr(CSR_SPARE_LOW, 7'h7F);
      write_csr(CSR_SPARE_HIGH, 7'h00);
      csr_valid <= 1'b0;
      send_price(32'h1234_5678, 1'b0);
      send_price(32'h8000_0000, 1'b1);
      send_price(32'h7FFF_FFFF, 1'b0);
      send_price(32'h8000_0000, 1'b0);
      // Unusable window pairs.
      set_windows(0, 10);
      send_price(32'h5555_5555, 1'b0);
      set_windows(10, 10);
      send_price(32'hAAAA_AAAA, 1'b0);
      set_windows(30, 20);
      send_price(32'h0000_0001, 1'b0);
      set_windows(5, 65);
      send_price(32'h8000_0000, 1'b1);
      set_windows(127, 127);
      send_price(32'hFFFF_FFFF, 1'b0);
      set_windows(1, 0);
      send_price(32'h0000_0000, 1'b0);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               short_w = 63;
               long_w  = 64;
               items   = 200;
            end
            1: begin
               short_w = 1;
               long_w  = 64;
               items   = 150;
            end
            2: begin
               short_w = SHORT_WINDOW_RESET;
               long_w  = LONG_WINDOW_RESET;
               items   = 300;
            end
            default: begin
               if ($urandom_range(99) < 80) begin
                  long_w  = ($urandom_range(3) != 0) ? $urandom_range(2, 12) :
                                                       $urandom_range(13, 64);
                  short_w = $urandom_range(1, long_w - 1);
               end else begin
                  short_w = $urandom_range(0, 127);
                  long_w  = $urandom_range(0, 127);
               end
               items = long_w + $urandom_range(20, 80);
            end
         endcase
         if (phase > 2 && $urandom_range(4) == 0) begin
            drain();
            write_csr(CSR_LONG_WINDOW, csr_data_type'(long_w));
            csr_valid <= 1'b0;
         end else begin
            set_windows(short_w, long_w);
         end
         if (phase == 1 || phase == 6) holds_asked <= holds_asked + 1;
         if (phase == 2) steady_run <= 1'b1;
         run_phase(items, $urandom_range(3), ($urandom_range(9) == 0) ? 15 : 1);
         steady_run <= 1'b0;
         sent  = sent + items;
         phase = phase + 1;
      end

      drain();
      repeat (10) @(negedge clock);
      if (book.failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
